// ----- src/ihmm_pkg.sv -----
// Package for the image histogram mean/median block: widths, types, the
// controller state encoding and the pixel-to-bin mapping function.
// Used by every module under src; depends on nothing.
package ihmm_pkg;

    localparam int NUM_BINS    = 15;
    localparam int CLASS_WIDTH = 17;
    localparam int BIN_W       = 4;
    localparam int PIX_W       = 8;
    localparam int COUNT_W     = 25;
    localparam int SUM_W       = 32;
    localparam int DIV_W       = 32;
    localparam int DIV_CNT_W   = 5;

    localparam logic [COUNT_W-1:0] MAX_PIXELS = 25'd16777216;
    localparam logic [BIN_W-1:0]   LAST_BIN   = 4'(NUM_BINS - 1);

    typedef logic [BIN_W-1:0]   bin_idx_t;
    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [DIV_W-1:0]   div_word_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_WALK,
        ST_MED_START,
        ST_MED_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     inc;
        logic     clear;
        pix_t     pixel;
        bin_idx_t addr;
    } hist_cmd_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Bin 0 holds 0..17; bin k holds 17k+1..17(k+1), so the bin is the number
    // of class edges 17k (k = 1..14) that the pixel lies above.
    function automatic bin_idx_t bin_of(input pix_t p);
        bin_idx_t b;
        b = '0;
        for (int k = 1; k < NUM_BINS; k++) begin
            if (p > PIX_W'(CLASS_WIDTH * k)) begin
                b = b + 4'd1;
            end
        end
        return b;
    endfunction

endpackage

// ----- src/ihmm_divider.sv -----
// Shared restoring divider, one quotient bit per cycle for a 32-bit quotient.
// Used for both the mean and the median interpolation; depends on ihmm_pkg.
module ihmm_divider (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ihmm_pkg::div_ctrl_t    ctrl,
    input  ihmm_pkg::div_word_t    dividend,
    input  ihmm_pkg::count_t       divisor,
    output ihmm_pkg::div_stat_t    stat,
    output ihmm_pkg::div_word_t    quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [ihmm_pkg::DIV_CNT_W-1:0]    cnt_reg;
    ihmm_pkg::div_word_t               quo_reg;
    ihmm_pkg::count_t                  rem_reg;
    logic [ihmm_pkg::COUNT_W:0]        shifted;
    logic [ihmm_pkg::COUNT_W+1:0]      diff;
    logic                              borrow;

    assign shifted = {rem_reg, quo_reg[ihmm_pkg::DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};
    assign borrow  = diff[ihmm_pkg::COUNT_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {ihmm_pkg::DIV_CNT_W{1'b1}}) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[ihmm_pkg::DIV_W-2:0], ~borrow};
            rem_reg <= borrow ? shifted[ihmm_pkg::COUNT_W-1:0]
                              : diff[ihmm_pkg::COUNT_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- src/ihmm_hist.sv -----
// Histogram store: fifteen bin counters, the pixel count and the pixel sum,
// with one shared bin address for update and readout. Depends on ihmm_pkg.
module ihmm_hist (
    input  logic                aclk,
    input  logic                aresetn,
    input  ihmm_pkg::hist_cmd_t cmd,
    output ihmm_pkg::count_t    rd_count,
    output ihmm_pkg::count_t    pixel_count,
    output ihmm_pkg::sum_t      pixel_sum
);

    ihmm_pkg::count_t bins_reg [ihmm_pkg::NUM_BINS];
    ihmm_pkg::count_t count_reg;
    ihmm_pkg::sum_t   sum_reg;
    logic             addr_ok;

    assign addr_ok  = (cmd.addr <= ihmm_pkg::LAST_BIN);
    assign rd_count = addr_ok ? bins_reg[cmd.addr] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < ihmm_pkg::NUM_BINS; i++) begin
                bins_reg[i] <= '0;
            end
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (cmd.inc) begin
            if (addr_ok) begin
                bins_reg[cmd.addr] <= rd_count + 1'b1;
            end
            count_reg <= count_reg + 1'b1;
            sum_reg   <= sum_reg + ihmm_pkg::SUM_W'(cmd.pixel);
        end
    end

    assign pixel_count = count_reg;
    assign pixel_sum   = sum_reg;

endmodule

// ----- src/image_histogram_mean_median.sv -----
// Top level: accepts one pixel beat per cycle while accumulating; the last
// pixel of an image starts a sequencer that runs the shared divider for the
// mean, walks the bins and runs the divider again for the median. An empty
// image skips the divisions and the walk and goes straight to the result.
// Pixels of the next image are accepted while the previous result waits.
// Synchronous active-low reset clears the histogram store and all control.
module image_histogram_mean_median (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ihmm_pkg::pix_t      s_pixel,
    input  logic                s_last_pixel,
    output logic                m_valid,
    input  logic                m_ready,
    output ihmm_pkg::pix_t      m_mean_value,
    output ihmm_pkg::pix_t      m_median_value
);

    ihmm_pkg::state_t     state_reg;
    ihmm_pkg::state_t     state_next;

    ihmm_pkg::hist_cmd_t  hist_cmd;
    ihmm_pkg::count_t     rd_count;
    ihmm_pkg::count_t     pixel_count;
    ihmm_pkg::sum_t       pixel_sum;

    ihmm_pkg::div_ctrl_t  div_ctrl;
    ihmm_pkg::div_stat_t  div_stat;
    ihmm_pkg::div_word_t  div_dividend;
    ihmm_pkg::count_t     div_divisor;
    ihmm_pkg::div_word_t  quotient;
    logic                 med_sel;

    ihmm_pkg::bin_idx_t   walk_idx_reg;
    ihmm_pkg::count_t     run_reg;
    ihmm_pkg::count_t     half_reg;
    ihmm_pkg::count_t     before_reg;
    ihmm_pkg::count_t     fk_reg;
    ihmm_pkg::bin_idx_t   k_reg;
    ihmm_pkg::pix_t       mean_reg;
    ihmm_pkg::pix_t       median_reg;

    logic                 m_valid_reg;
    ihmm_pkg::pix_t       m_mean_reg;
    ihmm_pkg::pix_t       m_median_reg;

    ihmm_pkg::count_t     new_run;
    logic                 walk_hit;
    logic                 med_skip;
    ihmm_pkg::count_t     med_diff;
    ihmm_pkg::div_word_t  med_num;
    ihmm_pkg::pix_t       k_base;
    logic                 out_free;
    logic                 out_load;
    logic                 accept;
    logic                 room;

    ihmm_hist u_hist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (hist_cmd),
        .rd_count    (rd_count),
        .pixel_count (pixel_count),
        .pixel_sum   (pixel_sum)
    );

    ihmm_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign accept   = s_valid && s_ready;
    assign room     = (pixel_count < ihmm_pkg::MAX_PIXELS);
    assign new_run  = run_reg + rd_count;
    assign walk_hit = (new_run >= half_reg) || (walk_idx_reg == ihmm_pkg::LAST_BIN);
    assign med_skip = (fk_reg == '0) || (half_reg < before_reg);
    assign med_diff = half_reg - before_reg;
    assign med_num  = (ihmm_pkg::DIV_W'(med_diff) << 4) + ihmm_pkg::DIV_W'(med_diff);
    assign k_base   = ({4'b0000, k_reg} << 4) + {4'b0000, k_reg};
    assign out_free = !m_valid_reg || m_ready;

    assign div_dividend = med_sel ? med_num : ihmm_pkg::DIV_W'(pixel_sum);
    assign div_divisor  = med_sel ? fk_reg : pixel_count;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ihmm_pkg::ST_ACCUM: begin
                if (accept && s_last_pixel) begin
                    state_next = ihmm_pkg::ST_MEAN_START;
                end
            end
            ihmm_pkg::ST_MEAN_START: begin
                state_next = (pixel_count == '0) ? ihmm_pkg::ST_DONE
                                                 : ihmm_pkg::ST_MEAN_WAIT;
            end
            ihmm_pkg::ST_MEAN_WAIT: begin
                if (div_stat.done) begin
                    state_next = ihmm_pkg::ST_WALK;
                end
            end
            ihmm_pkg::ST_WALK: begin
                if (walk_hit) begin
                    state_next = ihmm_pkg::ST_MED_START;
                end
            end
            ihmm_pkg::ST_MED_START: begin
                state_next = med_skip ? ihmm_pkg::ST_DONE : ihmm_pkg::ST_MED_WAIT;
            end
            ihmm_pkg::ST_MED_WAIT: begin
                if (div_stat.done) begin
                    state_next = ihmm_pkg::ST_DONE;
                end
            end
            ihmm_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ihmm_pkg::ST_ACCUM;
                end
            end
            default: begin
                state_next = ihmm_pkg::ST_ACCUM;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        hist_cmd.inc   = 1'b0;
        hist_cmd.clear = 1'b0;
        hist_cmd.pixel = s_pixel;
        hist_cmd.addr  = walk_idx_reg;
        div_ctrl.start = 1'b0;
        med_sel        = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ihmm_pkg::ST_ACCUM: begin
                s_ready       = 1'b1;
                hist_cmd.addr = ihmm_pkg::bin_of(s_pixel);
                hist_cmd.inc  = s_valid && room;
            end
            ihmm_pkg::ST_MEAN_START: begin
                div_ctrl.start = (pixel_count != '0);
            end
            ihmm_pkg::ST_MEAN_WAIT: begin
                med_sel = 1'b0;
            end
            ihmm_pkg::ST_WALK: begin
                hist_cmd.addr = walk_idx_reg;
            end
            ihmm_pkg::ST_MED_START: begin
                med_sel        = 1'b1;
                div_ctrl.start = !med_skip;
            end
            ihmm_pkg::ST_MED_WAIT: begin
                med_sel = 1'b1;
            end
            ihmm_pkg::ST_DONE: begin
                out_load       = out_free;
                hist_cmd.clear = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ihmm_pkg::ST_ACCUM;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ihmm_pkg::ST_MEAN_START: begin
                mean_reg   <= '0;
                median_reg <= '0;
            end
            ihmm_pkg::ST_MEAN_WAIT: begin
                if (div_stat.done) begin
                    mean_reg     <= quotient[ihmm_pkg::PIX_W-1:0];
                    walk_idx_reg <= '0;
                    run_reg      <= '0;
                    half_reg     <= pixel_count >> 1;
                end
            end
            ihmm_pkg::ST_WALK: begin
                if (walk_hit) begin
                    k_reg      <= walk_idx_reg;
                    before_reg <= run_reg;
                    fk_reg     <= rd_count;
                end else begin
                    run_reg      <= new_run;
                    walk_idx_reg <= walk_idx_reg + 1'b1;
                end
            end
            ihmm_pkg::ST_MED_START: begin
                median_reg <= k_base;
            end
            ihmm_pkg::ST_MED_WAIT: begin
                if (div_stat.done) begin
                    median_reg <= k_base + quotient[ihmm_pkg::PIX_W-1:0];
                end
            end
            default: begin
                mean_reg <= mean_reg;
            end
        endcase
        if (out_load) begin
            m_mean_reg   <= mean_reg;
            m_median_reg <= median_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mean_value   = m_mean_reg;
    assign m_median_value = m_median_reg;

endmodule
